@@ hdl/rtpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rtpe_pkg
// shared types, constants and sequencer states of the resonant tank estimator
// ----------------------------------------------------------------------------
package rtpe_pkg;

    localparam int MAX_SAMPLES_DEF  = 256;
    localparam int NUM_CHANNELS_DEF = 4;

    localparam logic [63:0] CLK_EFF     = 64'd768000000;
    localparam logic [17:0] SPACING_MIN = 18'd2500;
    localparam logic [17:0] SPACING_MAX = 18'd20000;
    localparam logic [31:0] INT32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN   = 32'h8000_0000;
    localparam int DIV_W = 64;

    typedef struct packed {
        logic [15:0] current_sample;
        logic [15:0] timer_sample;
        logic [15:0] voltage_sample;
        logic        last_sample;
        logic [1:0]  channel;
        logic [15:0] switch_on_time;
        logic [15:0] switch_off_time;
        logic [15:0] pwm_period;
    } sample_t;

    typedef struct packed {
        logic [1:0]         result_channel;
        logic [17:0]        resonant_freq;
        logic signed [31:0] q_factor;
        logic signed [31:0] inductance;
        logic [15:0]        peak_current;
        logic [2:0]         valid_flags;
        logic [15:0]        switch_freq;
        logic [31:0]        cycle_count;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_FSW, ST_FSW_W,
        ST_SCAN_INIT, ST_SCAN_RD, ST_SCAN_EV, ST_SCAN_END,
        ST_PAIR,
        ST_T1_RD, ST_T1_EV, ST_T2_RD, ST_T2_EV,
        ST_F0, ST_F0_W,
        ST_ANG_MUL, ST_ANG, ST_ANG_W,
        ST_F0SQ, ST_FSWSQ, ST_QCHK, ST_QM1, ST_QM2, ST_QDIV, ST_QDIV_W,
        ST_RISE_INIT, ST_RISE_RD, ST_RISE_EV, ST_RISE_CHK,
        ST_RE_RD, ST_RE_EV, ST_RS_RD, ST_RS_EV,
        ST_VS_RD, ST_VS_EV,
        ST_VB, ST_VB_W, ST_LMUL, ST_LDIV, ST_LDIV_W,
        ST_DONE
    } state_t;

endpackage

@@ hdl/rtpe_div.sv @@
// ----------------------------------------------------------------------------
// rtpe_div
// shared unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtpe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rtpe_pkg::div_req_t req,
    output rtpe_pkg::div_rsp_t rsp
);
    import rtpe_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DIV_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        shifted  = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ hdl/resonant_tank_parameter_estimator.sv @@
// ----------------------------------------------------------------------------
// resonant_tank_parameter_estimator
// collects one pwm cycle of samples, then estimates f0, q and inductance
// ----------------------------------------------------------------------------
//  channel   words        handshake                    payload
//  sample    in           sample_valid / sample_ready  rtpe_pkg::sample_t
//  result    out          result_valid / result_ready  rtpe_pkg::result_t
//
//  an ordinary sample word is taken whenever the sequencer is idle
//  a last-sample word holds the block until its result is loaded:
//  one pass of the shared divider per quotient (up to six) and
//  a read state and an evaluate state per store word for valleys, rise and voltage sum
//  reset clears the sample count, peak, per-channel counters and sequencer
//  a waiting result does not block new sample words; the next analysis
//  holds in its final step until the result register is free
// ----------------------------------------------------------------------------
module resonant_tank_parameter_estimator #(
    parameter int MAX_SAMPLES  = rtpe_pkg::MAX_SAMPLES_DEF,
    parameter int NUM_CHANNELS = rtpe_pkg::NUM_CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  rtpe_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output rtpe_pkg::result_t result
);
    import rtpe_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int VS_W  = 16 + CNT_W;

    state_t state_reg, state_next;

    // sample stores
    logic [15:0] cur_mem [MAX_SAMPLES];
    logic [15:0] tim_mem [MAX_SAMPLES];
    logic [15:0] vol_mem [MAX_SAMPLES];
    logic [IDX_W-1:0] rd_addr;
    logic [15:0] cur_q, tim_q, vol_q;

    // load side
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      peak_reg;
    logic             accept, store_en, ch_ok;
    logic [CNT_W-1:0] cnt_after;
    logic [15:0]      peak_after;

    // captured cycle info
    logic [1:0]       ch_reg;
    logic [15:0]      on_reg, off_reg, per_reg;
    logic [CNT_W-1:0] num_reg, half_reg;
    logic [15:0]      opk_reg;
    logic [29:0]      fsw_reg;

    // valley search
    logic             pass_reg, was_rise_reg;
    logic [CNT_W-1:0] idx_reg, pick_reg, zc1_reg, zc2_reg;
    logic [16:0]      best_reg;
    logic [15:0]      p1_reg, p2_reg;
    logic [CNT_W-1:0] lo, hi;
    logic             scan_empty, scan_first, scan_last, rising, trig, better, pick_upd;
    logic [16:0]      zr;

    // frequency and q
    logic [15:0] t1_reg;
    logic [17:0] dh_reg, t2_ext, dh_calc;
    logic        dh_ok, pair_ok, q_cond;
    logic [17:0] f0_reg;
    logic [23:0] angnum_reg;
    logic        ang_ok_reg;
    logic [6:0]  ang_reg;
    logic [35:0] f0sq_reg;
    logic [59:0] fswsq_reg;
    logic [14:0] tq;
    logic [14:0] tq_reg;
    logic [31:0] qm_reg;
    logic [61:0] qnum_reg;
    logic        q_go;

    // inductance
    logic [CNT_W-1:0] re_reg;
    logic [15:0]      pk_reg, cre_reg, tre_reg, dt_reg, dimag_reg, vbus_reg;
    logic             dineg_reg;
    logic [VS_W-1:0]  vsum_reg;
    logic [31:0]      lprod_reg;
    logic [CNT_W:0]   rise_nxt;
    logic             rise_go, brk, rise_chk;
    logic signed [16:0] di;
    logic             di_ok;
    logic [25:0]      lden;

    // results
    logic [31:0] q_reg, l_reg;
    logic [2:0]  flags_reg;
    logic [31:0] q_sat, l_sat;
    result_t     result_reg;
    logic        result_valid_reg;
    logic [31:0] cyc_reg [NUM_CHANNELS];
    logic [31:0] cyc_sel;
    logic        out_load;

    // shared units
    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    rtpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign prod = op_a * op_b;

    // helper terms
    always_comb
    begin
        accept     = sample_valid && sample_ready;
        store_en   = cnt_reg < CNT_W'(MAX_SAMPLES);
        cnt_after  = store_en ? cnt_reg + 1'b1 : cnt_reg;
        peak_after = (store_en && sample.current_sample > peak_reg)
                     ? sample.current_sample : peak_reg;
        ch_ok      = 32'(sample.channel) < 32'(NUM_CHANNELS);

        // scan window of the current pass
        lo         = pass_reg ? half_reg : CNT_W'(4);
        hi         = pass_reg ? (num_reg - 1'b1) : half_reg;
        scan_empty = lo >= hi;
        scan_first = idx_reg == lo;
        scan_last  = (idx_reg + 1'b1) == hi;
        rising     = cur_q > p1_reg;
        trig       = !scan_first && !was_rise_reg && rising;
        zr         = {1'b0, p2_reg} + {1'b0, cur_q};
        better     = trig && (best_reg > zr);
        pick_upd   = better && (p1_reg <= zr[16:1]);

        pair_ok = (zc1_reg >= CNT_W'(4)) && (zc2_reg > zc1_reg);
        // second valley time, unwrapped across the timer period
        t2_ext  = {2'b00, tim_q} + ((tim_q < t1_reg) ? {2'b00, per_reg} : 18'd0);
        dh_calc = t2_ext - {2'b00, t1_reg};
        dh_ok   = !dh_calc[17] && (dh_calc >= SPACING_MIN) && (dh_calc <= SPACING_MAX);
        q_cond  = (t1_reg > on_reg) && (off_reg > on_reg) && (per_reg != 16'd0);
        q_go    = ({24'd0, f0sq_reg} > fswsq_reg) && ang_ok_reg;

        // piecewise tangent slope
        if (ang_reg <= 7'd45)
            tq = 15'(ang_reg * 8'd71);
        else if (ang_reg <= 7'd75)
            tq = 15'(ang_reg * 8'd150);
        else
            tq = 15'd16384;

        // rise walk bounds
        rise_nxt = (state_reg == ST_RISE_INIT) ? ({1'b0, zc1_reg} + 1'b1)
                                               : ({1'b0, idx_reg} + 1'b1);
        rise_go  = (rise_nxt < {1'b0, half_reg}) &&
                   ((rise_nxt + 2'd2) < {1'b0, num_reg});
        brk      = ({1'b0, idx_reg} > ({1'b0, zc1_reg} + 2'd3)) &&
                   (cur_q < p1_reg) && (cur_q < p2_reg);
        rise_chk = {1'b0, re_reg} > ({1'b0, zc1_reg} + 2'd3);
        di       = $signed({1'b0, cre_reg}) - $signed({1'b0, cur_q});
        di_ok    = ((di > 17'sd10) || (di < 17'sd0)) && (tre_reg > tim_q);
        lden     = {1'b0, dimag_reg, 9'd0} + {2'b00, dimag_reg, 8'd0};

        // saturation of the quotients
        q_sat = (div_rsp.quo > {32'd0, INT32_MAX}) ? INT32_MAX : div_rsp.quo[31:0];
        if (dineg_reg)
            l_sat = (div_rsp.quo > {32'd0, INT32_MIN}) ? INT32_MIN
                                                        : (32'd0 - div_rsp.quo[31:0]);
        else
            l_sat = (div_rsp.quo > {32'd0, INT32_MAX}) ? INT32_MAX : div_rsp.quo[31:0];

        cyc_sel = '0;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            if (32'(ch_reg) == k)
                cyc_sel = cyc_reg[k];
        end
        out_load = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept && sample.last_sample)
                              state_next = ch_ok ? ST_FSW : ST_IDLE;
            ST_FSW:       state_next = (per_reg != 16'd0) ? ST_FSW_W : ST_SCAN_INIT;
            ST_FSW_W:     if (div_rsp.done) state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = scan_empty ? ST_SCAN_END : ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_EV;
            ST_SCAN_EV:   state_next = scan_last ? ST_SCAN_END : ST_SCAN_RD;
            ST_SCAN_END:  state_next = pass_reg ? ST_PAIR : ST_SCAN_INIT;
            ST_PAIR:      state_next = pair_ok ? ST_T1_RD : ST_DONE;
            ST_T1_RD:     state_next = ST_T1_EV;
            ST_T1_EV:     state_next = ST_T2_RD;
            ST_T2_RD:     state_next = ST_T2_EV;
            ST_T2_EV:     state_next = dh_ok ? ST_F0 : ST_DONE;
            ST_F0:        state_next = ST_F0_W;
            ST_F0_W:      if (div_rsp.done) state_next = q_cond ? ST_ANG_MUL : ST_RISE_INIT;
            ST_ANG_MUL:   state_next = ST_ANG;
            ST_ANG:       state_next = ST_ANG_W;
            ST_ANG_W:     if (div_rsp.done) state_next = ST_F0SQ;
            ST_F0SQ:      state_next = ST_FSWSQ;
            ST_FSWSQ:     state_next = ST_QCHK;
            ST_QCHK:      state_next = q_go ? ST_QM1 : ST_RISE_INIT;
            ST_QM1:       state_next = ST_QM2;
            ST_QM2:       state_next = ST_QDIV;
            ST_QDIV:      state_next = ST_QDIV_W;
            ST_QDIV_W:    if (div_rsp.done) state_next = ST_RISE_INIT;
            ST_RISE_INIT: state_next = rise_go ? ST_RISE_RD : ST_RISE_CHK;
            ST_RISE_RD:   state_next = ST_RISE_EV;
            ST_RISE_EV:   state_next = (brk || !rise_go) ? ST_RISE_CHK : ST_RISE_RD;
            ST_RISE_CHK:  state_next = rise_chk ? ST_RE_RD : ST_DONE;
            ST_RE_RD:     state_next = ST_RE_EV;
            ST_RE_EV:     state_next = ST_RS_RD;
            ST_RS_RD:     state_next = ST_RS_EV;
            ST_RS_EV:     state_next = di_ok ? ST_VS_RD : ST_DONE;
            ST_VS_RD:     state_next = ST_VS_EV;
            ST_VS_EV:     state_next = (idx_reg == re_reg) ? ST_VB : ST_VS_RD;
            ST_VB:        state_next = ST_VB_W;
            ST_VB_W:      if (div_rsp.done) state_next = ST_LMUL;
            ST_LMUL:      state_next = ST_LDIV;
            ST_LDIV:      state_next = ST_LDIV_W;
            ST_LDIV_W:    if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // store address, multiplier operands, divider requests
    always_comb
    begin
        rd_addr       = '0;
        op_a          = '0;
        op_b          = '0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (state_reg)
            ST_SCAN_RD, ST_RISE_RD, ST_VS_RD: rd_addr = idx_reg[IDX_W-1:0];
            ST_T1_RD: rd_addr = zc1_reg[IDX_W-1:0];
            ST_T2_RD: rd_addr = zc2_reg[IDX_W-1:0];
            ST_RE_RD: rd_addr = re_reg[IDX_W-1:0];
            ST_RS_RD: rd_addr = zc1_reg[IDX_W-1:0];
            ST_FSW:
            begin
                div_req.start = per_reg != 16'd0;
                div_req.num   = CLK_EFF;
                div_req.den   = {48'd0, per_reg};
            end
            ST_F0:
            begin
                div_req.start = 1'b1;
                div_req.num   = CLK_EFF;
                div_req.den   = {45'd0, dh_reg, 1'b0};
            end
            ST_ANG_MUL:
            begin
                op_a = {16'd0, t1_reg - on_reg};
                op_b = 32'd180;
            end
            ST_ANG:
            begin
                div_req.start = 1'b1;
                div_req.num   = {40'd0, angnum_reg};
                div_req.den   = {48'd0, off_reg - on_reg};
            end
            ST_F0SQ:
            begin
                op_a = {14'd0, f0_reg};
                op_b = {14'd0, f0_reg};
            end
            ST_FSWSQ:
            begin
                op_a = {2'd0, fsw_reg};
                op_b = {2'd0, fsw_reg};
            end
            ST_QM1:
            begin
                op_a = {17'd0, tq_reg};
                op_b = {14'd0, f0_reg};
            end
            ST_QM2:
            begin
                op_a = qm_reg;
                op_b = {2'd0, fsw_reg};
            end
            ST_QDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {2'd0, qnum_reg};
                div_req.den   = {4'd0, {24'd0, f0sq_reg} - fswsq_reg};
            end
            ST_VB:
            begin
                div_req.start = 1'b1;
                div_req.num   = 64'(vsum_reg);
                div_req.den   = 64'(re_reg - zc1_reg + 1'b1);
            end
            ST_LMUL:
            begin
                op_a = {16'd0, vbus_reg};
                op_b = {16'd0, dt_reg};
            end
            ST_LDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {20'd0, lprod_reg, 12'd0};
                div_req.den   = {38'd0, lden};
            end
            default: ;
        endcase
    end

    assign sample_ready = state_reg == ST_IDLE;

    // sample stores, written on accept below the store depth and read registered
    always_ff @(posedge clk)
    begin
        if (accept && store_en)
        begin
            cur_mem[cnt_reg[IDX_W-1:0]] <= sample.current_sample;
            tim_mem[cnt_reg[IDX_W-1:0]] <= sample.timer_sample;
            vol_mem[cnt_reg[IDX_W-1:0]] <= sample.voltage_sample;
        end
        cur_q <= cur_mem[rd_addr];
        tim_q <= tim_mem[rd_addr];
        vol_q <= vol_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            peak_reg         <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++)
                cyc_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg  <= sample.last_sample ? '0 : cnt_after;
                peak_reg <= sample.last_sample ? '0 : peak_after;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
                for (int k = 0; k < NUM_CHANNELS; k++)
                begin
                    if (32'(ch_reg) == k)
                        cyc_reg[k] <= cyc_reg[k] + 1'b1;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && sample.last_sample)
                begin
                    ch_reg    <= sample.channel;
                    on_reg    <= sample.switch_on_time;
                    off_reg   <= sample.switch_off_time;
                    per_reg   <= sample.pwm_period;
                    num_reg   <= cnt_after;
                    half_reg  <= cnt_after >> 1;
                    opk_reg   <= peak_after;
                    fsw_reg   <= '0;
                    pass_reg  <= 1'b0;
                    f0_reg    <= '0;
                    q_reg     <= '0;
                    l_reg     <= '0;
                    flags_reg <= '0;
                end
            end
            ST_FSW_W:
                if (div_rsp.done) fsw_reg <= div_rsp.quo[29:0];
            ST_SCAN_INIT:
            begin
                idx_reg      <= lo;
                was_rise_reg <= 1'b1;
                best_reg     <= '1;
                pick_reg     <= '0;
            end
            ST_SCAN_EV:
            begin
                if (!scan_first)
                    was_rise_reg <= rising;
                if (better)
                    best_reg <= zr;
                if (pick_upd)
                    pick_reg <= idx_reg - 1'b1;
                p2_reg  <= p1_reg;
                p1_reg  <= cur_q;
                idx_reg <= idx_reg + 1'b1;
            end
            ST_SCAN_END:
            begin
                if (pass_reg)
                    zc2_reg <= pick_reg;
                else
                    zc1_reg <= pick_reg;
                pass_reg <= 1'b1;
            end
            ST_T1_EV: t1_reg <= tim_q;
            ST_T2_EV: dh_reg <= dh_calc;
            ST_F0_W:
            begin
                if (div_rsp.done)
                begin
                    f0_reg       <= div_rsp.quo[17:0];
                    flags_reg[0] <= 1'b1;
                end
            end
            ST_ANG_MUL: angnum_reg <= prod[23:0];
            ST_ANG_W:
            begin
                if (div_rsp.done)
                begin
                    ang_ok_reg <= div_rsp.quo < 64'd90;
                    ang_reg    <= div_rsp.quo[6:0];
                end
            end
            ST_F0SQ:  f0sq_reg  <= prod[35:0];
            ST_FSWSQ: fswsq_reg <= prod[59:0];
            ST_QCHK:  tq_reg    <= tq;
            ST_QM1:   qm_reg    <= prod[31:0];
            ST_QM2:   qnum_reg  <= prod[61:0];
            ST_QDIV_W:
            begin
                if (div_rsp.done)
                begin
                    q_reg        <= q_sat;
                    flags_reg[1] <= 1'b1;
                end
            end
            ST_RISE_INIT:
            begin
                idx_reg <= zc1_reg + 1'b1;
                pk_reg  <= '0;
                re_reg  <= zc1_reg;
            end
            ST_RISE_EV:
            begin
                if (cur_q > pk_reg)
                begin
                    pk_reg <= cur_q;
                    re_reg <= idx_reg;
                end
                p2_reg  <= p1_reg;
                p1_reg  <= cur_q;
                idx_reg <= idx_reg + 1'b1;
            end
            ST_RE_EV:
            begin
                cre_reg <= cur_q;
                tre_reg <= tim_q;
            end
            ST_RS_EV:
            begin
                dineg_reg <= di[16];
                dimag_reg <= di[16] ? 16'(-di) : di[15:0];
                dt_reg    <= tre_reg - tim_q;
                idx_reg   <= zc1_reg;
                vsum_reg  <= '0;
            end
            ST_VS_EV:
            begin
                vsum_reg <= vsum_reg + VS_W'(vol_q);
                idx_reg  <= idx_reg + 1'b1;
            end
            ST_VB_W:
                if (div_rsp.done) vbus_reg <= div_rsp.quo[15:0];
            ST_LMUL: lprod_reg <= prod[31:0];
            ST_LDIV_W:
            begin
                if (div_rsp.done)
                begin
                    l_reg        <= l_sat;
                    flags_reg[2] <= 1'b1;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            result_reg.result_channel <= ch_reg;
            result_reg.resonant_freq  <= f0_reg;
            result_reg.q_factor       <= q_reg;
            result_reg.inductance     <= l_reg;
            result_reg.peak_current   <= opk_reg;
            result_reg.valid_flags    <= flags_reg;
            result_reg.switch_freq    <= fsw_reg[15:0];
            result_reg.cycle_count    <= cyc_sel + 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // divider is only started when free
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // sample count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    // q and l are only flagged with a valid frequency
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.valid_flags[1] || result.valid_flags[2])
        |-> result.valid_flags[0])
        else $error("q or l flagged without frequency");

    // a loaded result reports its channel's incremented cycle count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result_valid && (result.cycle_count == $past(cyc_sel) + 32'd1))
        else $error("cycle count mismatch");

endmodule

@@ dv/tb_resonant_tank_parameter_estimator.sv @@
// ----------------------------------------------------------------------------
// tb_resonant_tank_parameter_estimator
// loads pwm cycles of current, timer and voltage samples into the estimator,
// predicts f0, q, inductance, peak and counters for every last-sample word
// and checks each result word field by field in arrival order
// ----------------------------------------------------------------------------
module tb_resonant_tank_parameter_estimator;

    timeunit 1ns;
    timeprecision 1ps;

    import rtpe_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int CHANNELS    = 4;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    // scoreboard: tank model state plus the queue of predicted result words
    class tank_scoreboard;
        logic [15:0] cur_mem [STORE_DEPTH];
        logic [15:0] tmr_mem [STORE_DEPTH];
        logic [15:0] vlt_mem [STORE_DEPTH];
        int unsigned n_loaded;
        logic [15:0] peak_run;
        logic [31:0] ch_cycles [CHANNELS];
        result_t     pending_results [$];
        int          errors;

        function new();
            n_loaded = 0;
            peak_run = '0;
            errors   = 0;
            foreach (ch_cycles[k]) ch_cycles[k] = '0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // valley search with rising detector over [lo, hi)
        function int unsigned valley(int unsigned lo, int unsigned hi);
            bit was_up, up;
            int unsigned best, pick, pt, zr;
            logic [15:0] prev, now;
            was_up = 1; best = 32'hFFFF_FFFF; pick = 0;
            if (lo >= hi || hi > STORE_DEPTH) return 0;
            prev = cur_mem[lo];
            for (int unsigned i = lo + 1; i < hi; i++)
            begin
                now = cur_mem[i];
                up = now > prev;
                if (!was_up && up)
                begin
                    pt = i - 1;
                    zr = cur_mem[pt-1] + cur_mem[i];
                    if (best > zr)
                    begin
                        best = zr;
                        if (cur_mem[pt] <= (zr >> 1)) pick = pt;
                    end
                end
                was_up = up;
                prev = now;
            end
            return pick;
        endfunction

        function void note_sample(sample_t s);
            int unsigned cnt, half, zc1, zc2, t1, t2, dh, f0, ang, rs, re, dtv, vsum, ch;
            longint fsw, df2, tq, q, l, di, vbus;
            logic [2:0] flags;
            logic [15:0] pk, pk_cur;
            result_t r;
            if (n_loaded < STORE_DEPTH)
            begin
                cur_mem[n_loaded] = s.current_sample;
                tmr_mem[n_loaded] = s.timer_sample;
                vlt_mem[n_loaded] = s.voltage_sample;
                n_loaded++;
                if (s.current_sample > peak_run) peak_run = s.current_sample;
            end
            if (!s.last_sample) return;
            cnt = n_loaded; pk_cur = peak_run;
            n_loaded = 0; peak_run = '0;
            ch = s.channel;
            flags = '0; f0 = 0; q = 0; l = 0;
            half = cnt / 2;
            zc1 = valley(4, half);
            zc2 = (cnt >= 1) ? valley(half, cnt - 1) : 0;
            if (zc1 >= 4 && zc2 > zc1)
            begin
                t1 = tmr_mem[zc1]; t2 = tmr_mem[zc2];
                if (t2 < t1) t2 += s.pwm_period;
                dh = t2 - t1;
                if (dh >= 2500 && dh <= 20000)
                begin
                    f0 = 768000000 / (2 * dh);
                    flags[0] = 1;
                    if (t1 > s.switch_on_time && s.switch_off_time > s.switch_on_time
                        && s.pwm_period != 0)
                    begin
                        ang = (t1 - s.switch_on_time) * 180
                              / (s.switch_off_time - s.switch_on_time);
                        fsw = 768000000 / longint'(s.pwm_period);
                        df2 = longint'(f0) * f0 - fsw * fsw;
                        if (df2 > 0 && ang < 90)
                        begin
                            if (ang <= 45) tq = longint'(ang) * 71;
                            else if (ang <= 75) tq = longint'(ang) * 150;
                            else tq = 16384;
                            q = sat32(tq * f0 * fsw / df2);
                            flags[1] = 1;
                        end
                    end
                    // rise from first valley to local peak
                    rs = zc1; re = zc1; pk = 0;
                    for (int unsigned i = zc1 + 1; i < half && longint'(i) < longint'(cnt) - 2;
                         i++)
                    begin
                        if (cur_mem[i] > pk)
                        begin
                            pk = cur_mem[i];
                            re = i;
                        end
                        if (i > zc1 + 3 && cur_mem[i] < cur_mem[i-1] && cur_mem[i] < cur_mem[i-2])
                            break;
                    end
                    if (re > rs + 3)
                    begin
                        di = longint'(cur_mem[re]) - longint'(cur_mem[rs]);
                        dtv = 0;
                        if (tmr_mem[re] > tmr_mem[rs]) dtv = tmr_mem[re] - tmr_mem[rs];
                        if ((di > 10 || di < 0) && dtv > 0)
                        begin
                            vsum = 0;
                            for (int unsigned i = rs; i <= re; i++) vsum += vlt_mem[i];
                            vbus = vsum / (re - rs + 1);
                            // signed throughout so a falling rise gives a negative value
                            l = sat32(vbus * longint'(dtv) * 4096 / (di * 768));
                            flags[2] = 1;
                        end
                    end
                end
            end
            ch_cycles[ch] = ch_cycles[ch] + 1;
            r.result_channel = ch;
            r.resonant_freq  = f0[17:0];
            r.q_factor       = q[31:0];
            r.inductance     = l[31:0];
            r.peak_current   = pk_cur;
            r.valid_flags    = flags;
            r.switch_freq    = s.pwm_period != 0 ? 16'(768000000 / int'(s.pwm_period)) : '0;
            r.cycle_count    = ch_cycles[ch];
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %p", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.result_channel !== exp_r.result_channel)
            begin
                $display("%0t: result_channel expected %0d actual %0d", $realtime,
                         exp_r.result_channel, got.result_channel);
                errors++;
            end
            if (got.resonant_freq !== exp_r.resonant_freq)
            begin
                $display("%0t: resonant_freq expected %0d actual %0d", $realtime,
                         exp_r.resonant_freq, got.resonant_freq);
                errors++;
            end
            if (got.q_factor !== exp_r.q_factor)
            begin
                $display("%0t: q_factor expected %0d actual %0d", $realtime,
                         exp_r.q_factor, got.q_factor);
                errors++;
            end
            if (got.inductance !== exp_r.inductance)
            begin
                $display("%0t: inductance expected %0d actual %0d", $realtime,
                         exp_r.inductance, got.inductance);
                errors++;
            end
            if (got.peak_current !== exp_r.peak_current)
            begin
                $display("%0t: peak_current expected %0d actual %0d", $realtime,
                         exp_r.peak_current, got.peak_current);
                errors++;
            end
            if (got.valid_flags !== exp_r.valid_flags)
            begin
                $display("%0t: valid_flags expected %0b actual %0b", $realtime,
                         exp_r.valid_flags, got.valid_flags);
                errors++;
            end
            if (got.switch_freq !== exp_r.switch_freq)
            begin
                $display("%0t: switch_freq expected %0d actual %0d", $realtime,
                         exp_r.switch_freq, got.switch_freq);
                errors++;
            end
            if (got.cycle_count !== exp_r.cycle_count)
            begin
                $display("%0t: cycle_count expected %0d actual %0d", $realtime,
                         exp_r.cycle_count, got.cycle_count);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_ready;
    sample_t sample;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    tank_scoreboard board;
    longint cycle_no;
    int     words_sent;
    bit     allow_stall;

    resonant_tank_parameter_estimator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on a free-running cycle counter
    initial
    begin
        cycle_no = 0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: ready toggled at falling edges, words taken at rising edges
    initial
    begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = allow_stall ? $urandom_range(0, 12) : 0;
            repeat (gap) @(negedge clk);
            @(negedge clk);
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            board.check_result(result);
            @(negedge clk);
            result_ready <= 1'b0;
        end
    end

    // send one sample word, with a random hold-off before it; valid stays
    // high into the next word when there is no hold-off
    task automatic send_word(sample_t w);
        int gap;
        gap = allow_stall ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample       <= w;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        board.note_sample(w);
        words_sent++;
        @(negedge clk);
    endtask

    // one pwm cycle: a triangular resonant current shaped so that valleys and a
    // clear rise show up, timer counts spaced by tick_step
    task automatic send_tank_cycle(int n, int tick_step, logic [1:0] ch, bit noisy,
                                   logic [15:0] period_w);
        sample_t w;
        int      phase_len;
        int      base;
        phase_len = $urandom_range(6, 14);
        base      = $urandom_range(0, 65535);
        for (int i = 0; i < n; i++)
        begin
            int c;
            c = 20000 + ((i % phase_len) < phase_len / 2 ?
                         (i % phase_len) * 2000 : (phase_len - (i % phase_len)) * 2000);
            if (noisy) c = $urandom_range(0, 65535);
            else c = c + $urandom_range(0, 300);
            w.current_sample  = 16'(c);
            w.timer_sample    = 16'(base + i * tick_step);
            w.voltage_sample  = 16'($urandom_range(0, 65535));
            w.last_sample     = (i == n - 1);
            w.channel         = ch;
            w.switch_on_time  = 16'($urandom_range(0, 65535));
            w.switch_off_time = 16'($urandom_range(0, 65535));
            w.pwm_period      = period_w;
            if (w.last_sample && $urandom_range(0, 1))
            begin
                w.switch_on_time  = 16'(base);
                w.switch_off_time = 16'(base + $urandom_range(1, n * tick_step));
            end
            send_word(w);
        end
    endtask

    initial
    begin
        sample_t w;
        int      n;
        board        = new();
        words_sent   = 0;
        allow_stall  = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, single-word cycle, every channel
        w = '1;
        send_word(w);
        w = '0;
        w.last_sample = 1'b1;
        send_word(w);
        for (int k = 0; k < CHANNELS; k++)
        begin
            w = '0;
            w.current_sample = 16'hFFFF;
            w.last_sample    = 1'b1;
            w.channel        = 2'(k);
            w.pwm_period     = (k == 3) ? 16'hFFFF : 16'(k);
            send_word(w);
        end
        // clean resonant cycles: frequency, q and rise paths
        send_tank_cycle(40, 300, 2'd1, 1'b0, 16'd40000);
        send_tank_cycle(64, 100, 2'd2, 1'b0, 16'd0);
        // store overflow: more than the store holds, then last sample
        allow_stall = 1'b1;
        send_tank_cycle(STORE_DEPTH + 6, 60, 2'd3, 1'b0, 16'd20000);
        sample_valid <= 1'b0;

        // hold off until the block has drained everything
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (1000) @(posedge clk);
        @(negedge clk);

        // random part: mostly shaped cycles, some noise cycles
        while (words_sent < 850)
        begin
            allow_stall = ($urandom_range(0, 5) != 0);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, STORE_DEPTH + 4)
                                              : $urandom_range(1, 48);
            send_tank_cycle(n, $urandom_range(20, 900), 2'($urandom_range(0, 3)),
                            $urandom_range(0, 4) == 0,
                            ($urandom_range(0, 7) == 0) ? 16'd0
                                                         : 16'($urandom_range(1, 65535)));
        end
        sample_valid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
